@@ rtl/pairwise_column_correlation_assert.svh @@
// Assertion helpers for the correlation block.
`ifndef PAIRWISE_COLUMN_CORRELATION_ASSERT_SVH
`define PAIRWISE_COLUMN_CORRELATION_ASSERT_SVH

// same-cycle implication
`define PCC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pcc check failed");

// next-cycle implication
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pcc check failed");

`endif

@@ rtl/pcc_pkg.sv @@
package pcc_pkg;

    localparam int MaxRows   = 4096;
    localparam int SampleW   = 16;
    localparam int CntW      = 13;
    localparam int SumW      = 28;
    localparam int SqW       = 44;
    localparam int ColW      = 16;
    localparam int CorrW     = 16;
    localparam int MulW      = 64;
    localparam int ChunkW    = 16;
    localparam int ChunkCnt  = MulW / ChunkW;
    localparam int ProdW     = 2 * MulW;
    localparam int SrchW     = 148;
    localparam int MagBits   = 16;
    localparam int FifoDepth = 2;

    // column snapshot handed from the accumulator to the engine
    typedef struct packed {
        logic [CntW-1:0]        n;
        logic signed [SumW-1:0] sx;
        logic signed [SumW-1:0] sy;
        logic [SqW-1:0]         sxx;
        logic [SqW-1:0]         syy;
        logic signed [SqW-1:0]  sxy;
        logic [ColW-1:0]        col;
    } t_snap;

    // request to the shared multiplier
    typedef struct packed {
        logic            start;
        logic [MulW-1:0] a;
        logic [MulW-1:0] b;
    } t_mul_req;

endpackage

@@ rtl/pcc_mul.sv @@
// 64x64 unsigned multiply, one 64x16 partial product per cycle.
module pcc_mul import pcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_req         i_req,
    output logic             o_done,
    output logic [ProdW-1:0] o_prod
);

    logic [MulW-1:0]        r_a;
    logic [MulW-1:0]        r_b;
    logic [MulW+ChunkW-1:0] r_pp;
    logic [ProdW-1:0]       r_acc;
    logic [2:0]             r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [2:0]             w_prev;

    assign w_prev = r_cnt - 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_cnt < 3'(ChunkCnt)) begin
                    r_pp <= r_a * r_b[ChunkW-1:0];
                    r_b  <= r_b >> ChunkW;
                end
                if (r_cnt != 3'd0) begin
                    r_acc <= r_acc + ({{(ProdW-MulW-ChunkW){1'b0}}, r_pp}
                                      << {w_prev, 4'b0000});
                end
                if (r_cnt == 3'(ChunkCnt)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/pcc_front.sv @@
// Row accumulator: one sample pair per cycle while the queue has room, emits a snapshot per column.
module pcc_front import pcc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [SampleW-1:0] i_x,
    input  logic [SampleW-1:0] i_y,
    input  logic               i_last,
    input  logic               i_full,
    output logic               o_ready,
    output logic               o_push,
    output t_snap              o_snap
);

    logic [CntW-1:0]        r_cnt;
    logic signed [SumW-1:0] r_sx;
    logic signed [SumW-1:0] r_sy;
    logic [SqW-1:0]         r_sxx;
    logic [SqW-1:0]         r_syy;
    logic signed [SqW-1:0]  r_sxy;
    logic [ColW-1:0]        r_col;

    logic [CntW-1:0]          n_cnt;
    logic signed [SumW-1:0]   n_sx;
    logic signed [SumW-1:0]   n_sy;
    logic [SqW-1:0]           n_sxx;
    logic [SqW-1:0]           n_syy;
    logic signed [SqW-1:0]    n_sxy;
    logic signed [2*SampleW-1:0] w_xx;
    logic signed [2*SampleW-1:0] w_yy;
    logic signed [2*SampleW-1:0] w_xy;
    logic                     w_acc;
    logic                     w_close;

    assign o_ready = !i_full;
    assign w_acc   = i_valid && o_ready;

    assign w_xx = $signed(i_x) * $signed(i_x);
    assign w_yy = $signed(i_y) * $signed(i_y);
    assign w_xy = $signed(i_x) * $signed(i_y);

    assign n_cnt = r_cnt + CntW'(1);
    assign n_sx  = r_sx + SumW'($signed(i_x));
    assign n_sy  = r_sy + SumW'($signed(i_y));
    assign n_sxx = r_sxx + {{(SqW-2*SampleW){1'b0}}, w_xx};
    assign n_syy = r_syy + {{(SqW-2*SampleW){1'b0}}, w_yy};
    assign n_sxy = r_sxy + SqW'(w_xy);

    // a column also closes when it hits the row limit
    assign w_close = w_acc && (i_last || n_cnt == CntW'(MaxRows));

    assign o_push     = w_close;
    assign o_snap.n   = n_cnt;
    assign o_snap.sx  = n_sx;
    assign o_snap.sy  = n_sy;
    assign o_snap.sxx = n_sxx;
    assign o_snap.syy = n_syy;
    assign o_snap.sxy = n_sxy;
    assign o_snap.col = r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
            r_col <= '0;
        end else if (w_close) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
            r_col <= r_col + ColW'(1);
        end else if (w_acc) begin
            r_cnt <= n_cnt;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sxx <= n_sxx;
            r_syy <= n_syy;
            r_sxy <= n_sxy;
        end
    end

endmodule

@@ rtl/pcc_fifo.sv @@
// Two-entry snapshot queue between accumulator and engine.
module pcc_fifo import pcc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_data,
    input  logic  i_pop,
    output t_snap o_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PtrW = $clog2(FifoDepth);

    t_snap           r_mem [FifoDepth];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [PtrW:0]   r_cnt;

    assign o_full  = (r_cnt == (PtrW+1)'(FifoDepth));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PtrW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (PtrW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PtrW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/pcc_back.sv @@
// Per-column engine: moment products on the shared multiplier, then a
// bit-at-a-time search for the rounded Q1.15 magnitude.
module pcc_back import pcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_snap            i_snap,
    output logic             o_pop,
    output t_mul_req         o_mreq,
    input  logic             i_mdone,
    input  logic [ProdW-1:0] i_prod,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CorrW-1:0] o_corr,
    output logic             o_vres,
    output logic [ColW-1:0]  o_col,
    output logic [CntW-1:0]  o_cnt
);

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_WAIT, S_TRY, S_TEST, S_FIN, S_OUT
    } t_state;

    t_state                r_state;
    t_snap                 r_snap;
    logic [2:0]            r_op;
    t_mul_req              r_mreq;
    logic signed [MulW-1:0] r_vx;
    logic signed [MulW-1:0] r_vy;
    logic signed [MulW-1:0] r_num;
    logic [SrchW-1:0]      r_d;
    logic [SrchW-1:0]      r_r;
    logic [SrchW-1:0]      r_a;
    logic [SrchW-1:0]      r_b;
    logic [SrchW-1:0]      r_t2;
    logic [SrchW-1:0]      r_td;
    logic [MagBits-1:0]    r_m;
    logic [3:0]            r_k;
    logic                  r_ok;
    logic                  r_neg;
    logic                  r_valid;
    logic [CorrW-1:0]      r_corr;
    logic                  r_vres;

    logic [SumW-1:0]       w_asx;
    logic [SumW-1:0]       w_asy;
    logic [SqW-1:0]        w_asxy;
    logic [MulW-1:0]       w_mag;
    logic [MulW-1:0]       w_pa;
    logic [MulW-1:0]       w_pb;
    logic signed [MulW-1:0] w_p;
    logic [SrchW-1:0]      w_lhs;
    logic [4:0]            w_k2;
    logic [4:0]            w_k1;

    assign w_asx  = r_snap.sx[SumW-1] ? SumW'(-r_snap.sx) : SumW'(r_snap.sx);
    assign w_asy  = r_snap.sy[SumW-1] ? SumW'(-r_snap.sy) : SumW'(r_snap.sy);
    assign w_asxy = r_snap.sxy[SqW-1] ? SqW'(-r_snap.sxy) : SqW'(r_snap.sxy);
    assign w_mag  = r_num[MulW-1] ? MulW'(-r_num) : MulW'(r_num);
    assign w_p    = $signed(i_prod[MulW-1:0]);
    assign w_k1   = {1'b0, r_k} + 5'd1;
    assign w_k2   = {r_k, 1'b0};
    assign w_lhs  = ((r_t2 - r_td) << 2) + r_d;

    // operand select per product step
    always_comb begin
        w_pa = '0;
        w_pb = '0;
        case (r_op)
            3'd0: begin
                w_pa = MulW'(r_snap.n);
                w_pb = MulW'(r_snap.sxx);
            end
            3'd1: begin
                w_pa = MulW'(w_asx);
                w_pb = MulW'(w_asx);
            end
            3'd2: begin
                w_pa = MulW'(r_snap.n);
                w_pb = MulW'(r_snap.syy);
            end
            3'd3: begin
                w_pa = MulW'(w_asy);
                w_pb = MulW'(w_asy);
            end
            3'd4: begin
                w_pa = MulW'(r_snap.n);
                w_pb = MulW'(w_asxy);
            end
            3'd5: begin
                w_pa = MulW'(w_asx);
                w_pb = MulW'(w_asy);
            end
            3'd6: begin
                w_pa = r_vx;
                w_pb = r_vy;
            end
            default: begin
                w_pa = w_mag;
                w_pb = w_mag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= '0;
            r_mreq.start <= 1'b0;
            r_ok         <= 1'b0;
        end else begin
            r_mreq.start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_snap  <= i_snap;
                        r_op    <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_mreq.start <= 1'b1;
                    r_mreq.a     <= w_pa;
                    r_mreq.b     <= w_pb;
                    r_state      <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_mdone) begin
                        r_op    <= r_op + 3'd1;
                        r_state <= S_LOAD;
                        case (r_op)
                            3'd0: r_vx <= w_p;
                            3'd1: r_vx <= r_vx - w_p;
                            3'd2: r_vy <= w_p;
                            3'd3: r_vy <= r_vy - w_p;
                            3'd4: r_num <= r_snap.sxy[SqW-1] ? -w_p : w_p;
                            3'd5: begin
                                r_num <= (r_snap.sx[SumW-1] ^ r_snap.sy[SumW-1])
                                         ? r_num + w_p : r_num - w_p;
                            end
                            3'd6: r_d <= SrchW'(i_prod);
                            default: begin
                                r_r     <= {i_prod[SrchW-33:0], 32'b0};
                                r_neg   <= r_num[MulW-1];
                                r_valid <= (r_vx != '0) && (r_vy != '0);
                                r_m     <= '0;
                                r_a     <= '0;
                                r_b     <= '0;
                                r_k     <= 4'(MagBits - 1);
                                r_state <= ((r_vx != '0) && (r_vy != '0)) ? S_TRY
                                                                         : S_FIN;
                            end
                        endcase
                    end
                end
                S_TRY: begin
                    // once the magnitude reaches one, no lower bit may be added
                    if (r_m[MagBits-1]) begin
                        r_k     <= r_k - 4'd1;
                        r_state <= (r_k == 4'd0) ? S_FIN : S_TRY;
                    end else begin
                        r_t2    <= r_a + (r_b << w_k1) + (r_d << w_k2);
                        r_td    <= r_b + (r_d << r_k);
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    // (2t-1)^2 * D = 4*t^2*D - 4*t*D + D
                    if (w_lhs <= r_r) begin
                        r_m <= r_m | (MagBits'(1) << r_k);
                        r_a <= r_t2;
                        r_b <= r_td;
                    end
                    r_k     <= r_k - 4'd1;
                    r_state <= (r_k == 4'd0) ? S_FIN : S_TRY;
                end
                S_FIN: begin
                    r_vres <= r_valid;
                    if (!r_valid) begin
                        r_corr <= '0;
                    end else if (r_neg) begin
                        r_corr <= CorrW'(-r_m);
                    end else if (r_m[MagBits-1]) begin
                        r_corr <= {1'b0, {(CorrW-1){1'b1}}};
                    end else begin
                        r_corr <= r_m;
                    end
                    r_ok    <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_ok    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign o_mreq  = r_mreq;
    assign o_valid = r_ok;
    assign o_corr  = r_corr;
    assign o_vres  = r_vres;
    assign o_col   = r_snap.col;
    assign o_cnt   = r_snap.n;

endmodule

@@ rtl/pairwise_column_correlation.sv @@
// Path: the closing row of a column goes through the column queue, 8 products
//   on the shared multiplier (built from 64x16 partial products), a search of
//   one magnitude bit at a time over 16 bits, then the finish and output
//   stages; a zero-variance column skips the magnitude search.
// Throughput: one sample pair per cycle while the column queue has room;
//   the engine takes a new column only once its last result has been taken.
// Reset (i_rst_n low, synchronous): sums, counts, queue and engine cleared.
module pairwise_column_correlation import pcc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // x_sample[15:0], y_sample[31:16]
    input  logic        i_s_axis_tlast,   // last_row
    // result out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // correlation[15:0], column_index[31:16],
                                          // sample_count[44:32], zero pad
    output logic        o_m_axis_tuser    // valid_res
);

    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;
    t_snap            w_snap_in;
    t_snap            w_snap_out;
    t_mul_req         w_mreq;
    logic             w_mdone;
    logic [ProdW-1:0] w_prod;
    logic [CorrW-1:0] w_corr;
    logic [ColW-1:0]  w_col;
    logic [CntW-1:0]  w_cnt;

    // accumulate rows; a closing row pushes the column snapshot
    pcc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_x     (i_s_axis_tdata[SampleW-1:0]),
        .i_y     (i_s_axis_tdata[2*SampleW-1:SampleW]),
        .i_last  (i_s_axis_tlast),
        .i_full  (w_full),
        .o_ready (o_s_axis_tready),
        .o_push  (w_push),
        .o_snap  (w_snap_in)
    );

    // short queue decouples the accumulator from the slow engine
    pcc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_snap_in),
        .i_pop   (w_pop),
        .o_data  (w_snap_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    pcc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    // variances, covariance, then the rounded ratio; result held until taken
    pcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_snap  (w_snap_out),
        .o_pop   (w_pop),
        .o_mreq  (w_mreq),
        .i_mdone (w_mdone),
        .i_prod  (w_prod),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_corr  (w_corr),
        .o_vres  (o_m_axis_tuser),
        .o_col   (w_col),
        .o_cnt   (w_cnt)
    );

    assign o_m_axis_tdata = {3'b000, w_cnt, w_col, w_corr};

`include "pairwise_column_correlation_assert.svh"

    // queue never written while full
    `PCC_ASSERT_NOW(a_no_overflow, w_push, !w_full)
    // a pushed column is visible to the engine next cycle
    `PCC_ASSERT_NEXT(a_push_seen, w_push, !w_empty)
    // a result never reports an empty column
    `PCC_ASSERT_NOW(a_cnt_nonzero, o_m_axis_tvalid, w_cnt != '0)
    // invalid columns carry zero correlation
    `PCC_ASSERT_NOW(a_invalid_zero, o_m_axis_tvalid && !o_m_axis_tuser, w_corr == '0)

endmodule
